// ===== hw/rtl/triangle_span_rasterizer_unit_assert.svh =====
// Assertion macros for the triangle span rasterizer checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TRIANGLE_SPAN_RASTERIZER_UNIT_ASSERT_SVH
`define TRIANGLE_SPAN_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define TSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tsr_pkg.sv =====
// Shared types and constants for the triangle span rasterizer.
// No dependencies.
package tsr_pkg;

  localparam int COORD_W         = 5;
  localparam int COLOR_W         = 3;
  localparam int SCREEN_SIZE_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t              vert_a_x;
    coord_t              vert_a_y;
    coord_t              vert_b_x;
    coord_t              vert_b_y;
    coord_t              vert_c_x;
    coord_t              vert_c_y;
    logic [COLOR_W-1:0]  fill_color;
  } tsr_in_t;

  typedef struct packed {
    coord_t              span_row;
    coord_t              span_left;
    coord_t              span_right;
    logic [COLOR_W-1:0]  span_color;
    logic                span_valid;
    logic                span_last;
  } tsr_out_t;

  // edge ordered by row: top end first
  typedef struct packed {
    coord_t xt;
    coord_t yt;
    coord_t xb;
    coord_t yb;
  } tsr_edge_t;

  typedef struct packed {
    tsr_edge_t           lng;
    tsr_edge_t           sh0;
    tsr_edge_t           sh1;
    logic [COLOR_W-1:0]  color;
  } tsr_job_t;

  typedef struct packed {
    logic   start;
    coord_t num;
    coord_t den;
  } tsr_div_req_t;

  typedef struct packed {
    logic   done;
    coord_t quo;
    coord_t rem;
  } tsr_div_rsp_t;

endpackage

// ===== hw/rtl/tsr_front.sv =====
// Front end: orders each edge of the triangle by row and picks the long edge.
// Depends on tsr_pkg.
module tsr_front import tsr_pkg::*; (
  input  tsr_in_t  tri_i,
  output tsr_job_t job_o
);

  function automatic tsr_edge_t make_edge(coord_t xa, coord_t ya, coord_t xb, coord_t yb);
    tsr_edge_t e;
    if (ya < yb) begin
      e = '{xt: xa, yt: ya, xb: xb, yb: yb};
    end else begin
      e = '{xt: xb, yt: yb, xb: xa, yb: ya};
    end
    return e;
  endfunction

  tsr_edge_t  e0, e1, e2;
  coord_t     len0, len1, len2;
  logic [1:0] lng_sel;

  always_comb begin
    e0   = make_edge(tri_i.vert_a_x, tri_i.vert_a_y, tri_i.vert_b_x, tri_i.vert_b_y);
    e1   = make_edge(tri_i.vert_b_x, tri_i.vert_b_y, tri_i.vert_c_x, tri_i.vert_c_y);
    e2   = make_edge(tri_i.vert_c_x, tri_i.vert_c_y, tri_i.vert_a_x, tri_i.vert_a_y);
    len0 = e0.yb - e0.yt;
    len1 = e1.yb - e1.yt;
    len2 = e2.yb - e2.yt;
    // ties keep the lower edge
    if (len2 > len1 && len2 > len0) begin
      lng_sel = 2'd2;
    end else if (len1 > len0) begin
      lng_sel = 2'd1;
    end else begin
      lng_sel = 2'd0;
    end
    job_o.color = tri_i.fill_color;
    unique case (lng_sel)
      2'd1: begin
        job_o.lng = e1; job_o.sh0 = e2; job_o.sh1 = e0;
      end
      2'd2: begin
        job_o.lng = e2; job_o.sh0 = e0; job_o.sh1 = e1;
      end
      default: begin
        job_o.lng = e0; job_o.sh0 = e1; job_o.sh1 = e2;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tsr_queue.sv =====
// Short job queue between the front end and the span walker.
// Depends on tsr_pkg.
module tsr_queue import tsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_i,
  input  tsr_job_t push_job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output tsr_job_t pop_job_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tsr_job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full_o    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_r == '0);
  assign pop_job_o = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push_i ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_job_i;
    end
  end

endmodule

// ===== hw/rtl/tsr_div.sv =====
// Restoring divider, one quotient bit per cycle, for edge slope setup.
// Depends on tsr_pkg.
module tsr_div import tsr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tsr_div_req_t req_i,
  output tsr_div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  coord_t           num_r, num_nxt;
  coord_t           den_r, den_nxt;
  coord_t           rem_r, rem_nxt;
  coord_t           quo_r, quo_nxt;
  logic [COORD_W:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, num_r[COORD_W-1]};
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(COORD_W);
      num_nxt  = req_i.num;
      den_nxt  = req_i.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = COORD_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[COORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COORD_W-1:0];
        quo_nxt = {quo_r[COORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quo  = quo_r;
  assign rsp_o.rem  = rem_r;

endmodule

// ===== hw/rtl/tsr_back.sv =====
// Back end: walks the long edge against each short edge, one row a cycle
// when not stalled; it holds one span back so the final word can carry
// span_last. Depends on tsr_pkg and tsr_div.
module tsr_back import tsr_pkg::*; #(
  parameter int SCREEN_SIZE = SCREEN_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty_i,
  input  tsr_job_t q_job_i,
  output logic     q_pop_o,
  output logic     out_valid,
  input  logic     out_stall,
  output tsr_out_t out_word
);

  localparam int SCR_W = $clog2(SCREEN_SIZE + 1) > COORD_W + 1 ?
                         $clog2(SCREEN_SIZE + 1) : COORD_W + 1;
  localparam logic [SCR_W-1:0] SCR = SCR_W'(SCREEN_SIZE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIVL  = 3'd2;
  localparam logic [2:0] S_DIVS  = 3'd3;
  localparam logic [2:0] S_SKIP  = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  typedef struct packed {
    coord_t q;
    coord_t r;
  } walk_t;

  // exact quotient stepping: q,r track floor(|dx|*k/dy) and its remainder
  function automatic walk_t walk_step(walk_t w, coord_t qd, coord_t rd, coord_t dy);
    logic [COORD_W:0] acc;
    walk_t            o;
    acc = {1'b0, w.r} + {1'b0, rd};
    if (acc >= {1'b0, dy}) begin
      o.r = COORD_W'(acc - {1'b0, dy});
      o.q = w.q + qd + 1'b1;
    end else begin
      o.r = acc[COORD_W-1:0];
      o.q = w.q + qd;
    end
    return o;
  endfunction

  function automatic coord_t edge_col(tsr_edge_t e, coord_t q);
    return (e.xb >= e.xt) ? e.xt + q : e.xt - q;
  endfunction

  function automatic coord_t abs_dx(tsr_edge_t e);
    return (e.xb >= e.xt) ? e.xb - e.xt : e.xt - e.xb;
  endfunction

  logic [2:0]   state_r, state_nxt;
  tsr_job_t     job_r, job_nxt;
  logic         sel_r, sel_nxt;
  coord_t       y_r, y_nxt;
  walk_t        wl_r, wl_nxt, ws_r, ws_nxt;
  coord_t       qdl_r, qdl_nxt, rdl_r, rdl_nxt;
  coord_t       qds_r, qds_nxt, rds_r, rds_nxt;
  logic         pend_v_r, pend_v_nxt;
  tsr_out_t     pend_r, pend_nxt;
  logic         out_valid_r, out_valid_nxt;
  tsr_out_t     out_r, out_nxt;

  tsr_div_req_t div_req;
  tsr_div_rsp_t div_rsp;

  tsr_edge_t        sh;
  coord_t           dyl, dys;
  coord_t           c1, c2, lft, rgt;
  logic [SCR_W-1:0] rgt_clip;
  logic             keep;
  logic             out_free;
  tsr_out_t         cand;

  tsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    sh       = sel_r ? job_r.sh1 : job_r.sh0;
    dyl      = job_r.lng.yb - job_r.lng.yt;
    dys      = sh.yb - sh.yt;
    c1       = edge_col(job_r.lng, wl_r.q);
    c2       = edge_col(sh, ws_r.q);
    lft      = (c1 < c2) ? c1 : c2;
    rgt      = (c1 < c2) ? c2 : c1;
    rgt_clip = (SCR_W'(rgt) > SCR) ? SCR : SCR_W'(rgt);
    keep     = (SCR_W'(y_r) < SCR) && (SCR_W'(lft) < rgt_clip);
    cand     = '{span_row: y_r, span_left: lft, span_right: rgt_clip[COORD_W-1:0],
                 span_color: job_r.color, span_valid: 1'b1, span_last: 1'b0};
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    sel_nxt       = sel_r;
    y_nxt         = y_r;
    wl_nxt        = wl_r;
    ws_nxt        = ws_r;
    qdl_nxt       = qdl_r;
    rdl_nxt       = rdl_r;
    qds_nxt       = qds_r;
    rds_nxt       = rds_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop_o       = 1'b0;
    div_req       = '{start: 1'b0, num: abs_dx(job_r.lng), den: dyl};

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o    = 1'b1;
          job_nxt    = q_job_i;
          sel_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_SETUP;
        end
      end
      S_SETUP: begin
        if (dyl == '0 || dys == '0) begin
          state_nxt = S_NEXT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIVL;
        end
      end
      S_DIVL: begin
        if (div_rsp.done) begin
          qdl_nxt       = div_rsp.quo;
          rdl_nxt       = div_rsp.rem;
          div_req.start = 1'b1;
          div_req.num   = abs_dx(sh);
          div_req.den   = dys;
          state_nxt     = S_DIVS;
        end
      end
      S_DIVS: begin
        if (div_rsp.done) begin
          qds_nxt   = div_rsp.quo;
          rds_nxt   = div_rsp.rem;
          wl_nxt    = '0;
          ws_nxt    = '0;
          y_nxt     = job_r.lng.yt;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // bring the long edge down to the short edge's top row
        if (y_r == sh.yt) begin
          state_nxt = S_ROW;
        end else begin
          wl_nxt = walk_step(wl_r, qdl_r, rdl_r, dyl);
          y_nxt  = y_r + 1'b1;
        end
      end
      S_ROW: begin
        if (!(keep && pend_v_r) || out_free) begin
          if (keep) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = cand;
          end
          wl_nxt = walk_step(wl_r, qdl_r, rdl_r, dyl);
          ws_nxt = walk_step(ws_r, qds_r, rds_r, dys);
          y_nxt  = y_r + 1'b1;
          if (y_r + 1'b1 == sh.yb) begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_SETUP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_nxt           = pend_r;
            out_nxt.span_last = 1'b1;
          end else begin
            // empty triangle marker
            out_nxt = '{span_row: '0, span_left: '0, span_right: '0,
                        span_color: job_r.color, span_valid: 1'b0, span_last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    sel_r  <= sel_nxt;
    y_r    <= y_nxt;
    wl_r   <= wl_nxt;
    ws_r   <= ws_nxt;
    qdl_r  <= qdl_nxt;
    rdl_r  <= rdl_nxt;
    qds_r  <= qds_nxt;
    rds_r  <= rds_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== hw/rtl/triangle_span_rasterizer_unit.sv =====
// Channel | Word     | Direction | Handshake
// in      | tsr_in_t  | input     | in_valid / in_stall
// out     | tsr_out_t | output    | out_valid / out_stall
//
// Per non-flat short edge a triangle passes through a setup state and two
// slope divisions, long edge first; the long edge then steps down to the
// short edge's top row, and the rows of that short edge are walked for spans.
// Flat edges skip the divisions and the walk, but not the setup state.
// Reset is synchronous, active low; the job queue takes two triangles while
// the walker works. out_stall holds the output register and blocks the walker.
// Depends on tsr_pkg, tsr_front, tsr_queue, tsr_back.
module triangle_span_rasterizer_unit import tsr_pkg::*; #(
  parameter int SCREEN_SIZE = SCREEN_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tsr_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output tsr_out_t out_word
);

  tsr_job_t fr_job;
  tsr_job_t q_job;
  logic     q_full, q_empty, q_pop;

  assign in_stall = q_full;

  tsr_front u_front (
    .tri_i (in_word),
    .job_o (fr_job)
  );

  tsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (in_valid && !q_full),
    .push_job_i (fr_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_job_o  (q_job)
  );

  tsr_back #(
    .SCREEN_SIZE (SCREEN_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (q_empty),
    .q_job_i   (q_job),
    .q_pop_o   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== hw/rtl/tsr_checker.sv =====
// Port-level checks for the triangle span rasterizer, bound to the top level.
// Depends on tsr_pkg and the assertion macro header.
`include "triangle_span_rasterizer_unit_assert.svh"

module tsr_checker import tsr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input tsr_in_t  in_word,
  input logic     out_valid,
  input logic     out_stall,
  input tsr_out_t out_word
);

  `TSR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word), "stalled input moved")
  `TSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")
  `TSR_ASSERT_NOW(a_marker_last, out_valid && !out_word.span_valid, out_word.span_last && out_word.span_row == '0 && out_word.span_left == '0 && out_word.span_right == '0, "empty marker malformed")
  `TSR_ASSERT_NOW(a_span_order, out_valid && out_word.span_valid, out_word.span_right > out_word.span_left, "span right not past left")

endmodule

bind triangle_span_rasterizer_unit tsr_checker u_tsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== test/tb.sv =====
// Self-checking testbench for triangle_span_rasterizer_unit.
// Drives triangles, predicts their spans and compares every output word.
// Depends on tsr_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import tsr_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tsr_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  tsr_out_t out_word;

  triangle_span_rasterizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  tsr_out_t span_q[$];
  int       mismatches;
  bit       hold_off;
  bit       quiet;
  int       n_dir;

  // directed triangles; exp_n > 0 means the single expected word is given
  typedef struct {
    tsr_in_t  tri_w;
    int       exp_n;
    tsr_out_t exp_w;
  } dir_row_t;
  dir_row_t dir_tab[20];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("triangle_span_rasterizer_unit regression: fail");
    $finish;
  end

  function automatic tsr_out_t mk_span(int row, int l, int r, int col,
                                       int vld, int lst);
    tsr_out_t w;
    w.span_row   = row[4:0];
    w.span_left  = l[4:0];
    w.span_right = r[4:0];
    w.span_color = col[2:0];
    w.span_valid = vld[0];
    w.span_last  = lst[0];
    return w;
  endfunction

  function automatic int edge_x(int xt, int yt, int xb, int yb, int y);
    if (yb == yt) return xt;
    return xt + ((xb - xt) * (y - yt)) / (yb - yt);
  endfunction

  // predicted spans of one triangle, pushed onto span_q
  task automatic predict_spans(input tsr_in_t t);
    int ex[3][4];
    int vx[3], vy[3];
    int lng, best, k, e, y, c1, c2, l, r, cnt, start;
    vx[0] = t.vert_a_x; vy[0] = t.vert_a_y;
    vx[1] = t.vert_b_x; vy[1] = t.vert_b_y;
    vx[2] = t.vert_c_x; vy[2] = t.vert_c_y;
    for (k = 0; k < 3; k++) begin
      int p, q;
      p = k; q = (k + 1) % 3;
      if (vy[p] < vy[q]) begin
        ex[k][0] = vx[p]; ex[k][1] = vy[p]; ex[k][2] = vx[q]; ex[k][3] = vy[q];
      end else begin
        ex[k][0] = vx[q]; ex[k][1] = vy[q]; ex[k][2] = vx[p]; ex[k][3] = vy[p];
      end
    end
    best = 0; lng = 0;
    for (k = 0; k < 3; k++)
      if (ex[k][3] - ex[k][1] > best) begin
        best = ex[k][3] - ex[k][1];
        lng = k;
      end
    cnt = 0;
    start = span_q.size();
    for (k = 1; k <= 2; k++) begin
      e = (lng + k) % 3;
      if (ex[lng][3] != ex[lng][1] && ex[e][3] != ex[e][1])
        for (y = ex[e][1]; y < ex[e][3]; y++) begin
          c1 = edge_x(ex[lng][0], ex[lng][1], ex[lng][2], ex[lng][3], y);
          c2 = edge_x(ex[e][0], ex[e][1], ex[e][2], ex[e][3], y);
          l = c1 < c2 ? c1 : c2;
          r = c1 < c2 ? c2 : c1;
          if (y >= SCREEN_SIZE_DEF) continue;
          if (r > SCREEN_SIZE_DEF) r = SCREEN_SIZE_DEF;
          if (l >= r || cnt >= 32) continue;
          span_q.push_back(mk_span(y, l, r, t.fill_color, 1, 0));
          cnt++;
        end
    end
    if (cnt == 0) span_q.push_back(mk_span(0, 0, 0, t.fill_color, 0, 1));
    else span_q[start + cnt - 1].span_last = 1'b1;
  endtask

  function automatic tsr_in_t mk_tri(int ax, int ay, int bx, int by, int cx,
                                     int cy, int col);
    tsr_in_t t;
    t = {ax[4:0], ay[4:0], bx[4:0], by[4:0], cx[4:0], cy[4:0], col[2:0]};
    return t;
  endfunction

  function automatic tsr_in_t rand_tri();
    tsr_in_t t;
    int sel;
    t = tsr_in_t'(33'({$urandom, $urandom}));
    sel = $urandom_range(0, 9);
    // half with a short row range, some degenerate ones, the rest random
    if (sel < 5) begin
      t.vert_b_y = coord_t'(t.vert_a_y + $urandom_range(0, 6) - 3);
      t.vert_c_y = coord_t'(t.vert_a_y + $urandom_range(0, 6) - 3);
    end else if (sel == 5) begin
      t.vert_b_y = t.vert_a_y;
    end else if (sel == 6) begin
      t.vert_c_x = t.vert_a_x;
      t.vert_b_x = t.vert_a_x;
    end
    return t;
  endfunction

  task automatic send_tri(input tsr_in_t t);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_word  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_spans(t);
    @(negedge clk);
  endtask

  // receiver stall generation, including one long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (quiet) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 12);
    end
  end

  // output checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_word);
      end else begin
        tsr_out_t w;
        w = span_q.pop_front();
        if (w.span_valid != out_word.span_valid || w.span_last != out_word.span_last ||
            w.span_color != out_word.span_color ||
            (w.span_valid && (w.span_row != out_word.span_row ||
             w.span_left != out_word.span_left ||
             w.span_right != out_word.span_right)) ||
            (!w.span_valid && w != out_word)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("span mismatch: expected %p, got %p", w, out_word);
        end
      end
    end
  end

  initial begin
    int i, wait_cyc;
    rst_n = 1'b0; in_valid = 1'b0; in_word = '0;
    mismatches = 0; hold_off = 0; quiet = 0;
    dir_tab[0]  = '{mk_tri(0, 0, 31, 0, 15, 0, 7), 1, mk_span(0, 0, 0, 7, 0, 1)};
    dir_tab[1]  = '{mk_tri(5, 5, 5, 5, 5, 5, 0), 1, mk_span(0, 0, 0, 0, 0, 1)};
    dir_tab[2]  = '{mk_tri(3, 0, 3, 31, 3, 9, 2), 1, mk_span(0, 0, 0, 2, 0, 1)};
    dir_tab[3]  = '{mk_tri(0, 0, 31, 0, 0, 31, 5), 0, '0};
    dir_tab[4]  = '{mk_tri(31, 31, 0, 0, 31, 0, 1), 0, '0};
    dir_tab[5]  = '{mk_tri(0, 0, 1, 1, 0, 2, 3), 0, '0};
    dir_tab[6]  = '{mk_tri(0, 0, 1, 0, 0, 1, 4), 1, mk_span(0, 0, 1, 4, 1, 1)};
    dir_tab[7]  = '{mk_tri(10, 0, 0, 31, 31, 31, 6), 0, '0};
    dir_tab[8]  = '{mk_tri(31, 5, 0, 20, 31, 31, 7), 0, '0};
    dir_tab[9]  = '{mk_tri(16, 0, 0, 16, 31, 16, 0), 0, '0};
    dir_tab[10] = '{mk_tri(0, 10, 31, 0, 31, 20, 1), 0, '0};
    dir_tab[11] = '{mk_tri(31, 0, 0, 31, 31, 31, 2), 0, '0};
    dir_tab[12] = '{mk_tri(0, 31, 31, 31, 15, 0, 3), 0, '0};
    dir_tab[13] = '{mk_tri(7, 3, 21, 3, 14, 30, 5), 0, '0};
    dir_tab[14] = '{mk_tri(0, 0, 31, 31, 0, 31, 6), 0, '0};
    dir_tab[15] = '{mk_tri(2, 0, 9, 11, 30, 22, 4), 0, '0};
    dir_tab[16] = '{mk_tri(31, 31, 31, 0, 0, 15, 7), 0, '0};
    dir_tab[17] = '{mk_tri(5, 5, 5, 6, 5, 7, 1), 1, mk_span(0, 0, 0, 1, 0, 1)};
    dir_tab[18] = '{mk_tri(21, 10, 10, 20, 31, 20, 2), 0, '0};
    dir_tab[19] = '{mk_tri(1, 30, 30, 1, 29, 31, 0), 0, '0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (i = 0; i < 20; i++) begin
      send_tri(dir_tab[i].tri_w);
      // older words may have drained meanwhile; this triangle's word is last
      n_dir = span_q.size() - 1;
      if (dir_tab[i].exp_n > 0) span_q[n_dir] = dir_tab[i].exp_w;
    end
    for (i = 0; i < 450; i++) begin
      if (i == 100) quiet = 1;
      if (i == 180) quiet = 0;
      if (i == 250) begin
        hold_off = 1;
        fork
          begin
            repeat (400) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      send_tri(rand_tri());
    end
    in_valid <= 1'b0;
    wait_cyc = 0;
    while (span_q.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && span_q.size() == 0)
      $display("triangle_span_rasterizer_unit regression: pass");
    else
      $display("triangle_span_rasterizer_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_front.sv
hw/rtl/tsr_queue.sv
hw/rtl/tsr_div.sv
hw/rtl/tsr_back.sv
hw/rtl/triangle_span_rasterizer_unit.sv
hw/rtl/tsr_checker.sv
test/tb.sv
